/* hw/rtl/int8_mac_requant_unit_top_assert.svh */
// Assertion macros shared by the int8 MAC and requantization unit.
`ifndef INT8_MAC_REQUANT_UNIT_TOP_ASSERT_SVH
`define INT8_MAC_REQUANT_UNIT_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IMRU_ASSERT_ALWAYS(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("assertion failed");
`define IMRU_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IMRU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IMRU_ASSERT_ALWAYS(lbl, ck, rn, cond)
`define IMRU_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define IMRU_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* hw/rtl/imru_pkg.sv */
// Shared types and constants of the int8 MAC and requantization unit.
package imru_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_LANES = 4;
    localparam int LANE_W    = 18;

    localparam logic [3:0] OP_MAC     = 4'd0;
    localparam logic [3:0] OP_CLRACC  = 4'd1;
    localparam logic [3:0] OP_PUSH    = 4'd2;
    localparam logic [3:0] OP_BUFMAC  = 4'd3;
    localparam logic [3:0] OP_CLRBUF  = 4'd4;
    localparam logic [3:0] OP_REQUANT = 4'd5;
    localparam logic [3:0] OP_ADD     = 4'd6;
    localparam logic [3:0] OP_SUB     = 4'd7;
    localparam logic [3:0] OP_MUL     = 4'd8;

    localparam logic [2:0] CFG_INPUT_OFFSET  = 3'd0;
    localparam logic [2:0] CFG_BIAS          = 3'd1;
    localparam logic [2:0] CFG_MULTIPLIER    = 3'd2;
    localparam logic [2:0] CFG_SHIFT         = 3'd3;
    localparam logic [2:0] CFG_OUTPUT_OFFSET = 3'd4;
    localparam logic [2:0] CFG_ACT_MIN       = 3'd5;
    localparam logic [2:0] CFG_ACT_MAX       = 3'd6;

    typedef logic signed [LANE_W-1:0] lane_prod_t;

    typedef struct packed {
        logic              push;
        logic              take;
        logic              clear;
        logic [WORD_W-1:0] wdata;
    } store_cmd_t;

endpackage

/* hw/rtl/imru_lane.sv */
// One dot-product lane: signed byte times offset-adjusted signed byte.
module imru_lane
(
    input  logic [7:0]          a_byte,
    input  logic [7:0]          b_byte,
    input  logic signed [8:0]   offset,
    output imru_pkg::lane_prod_t product
);

    logic signed [9:0] b_adj;

    assign b_adj   = {{2{b_byte[7]}}, b_byte} + {offset[8], offset};
    assign product = $signed(a_byte) * b_adj;

endmodule

/* hw/rtl/imru_merge.sv */
// Merges the lane products and adds them to the accumulator.
module imru_merge
(
    input  logic [31:0]          acc,
    input  imru_pkg::lane_prod_t products [imru_pkg::NUM_LANES],
    output logic [31:0]          sum
);

    logic signed [imru_pkg::LANE_W+1:0] lane_sum;

    always_comb
    begin
        lane_sum = '0;
        for (int i = 0; i < imru_pkg::NUM_LANES; i++)
        begin
            lane_sum = lane_sum + {{2{products[i][imru_pkg::LANE_W-1]}}, products[i]};
        end
    end

    assign sum = acc + {{(32-imru_pkg::LANE_W-2){lane_sum[imru_pkg::LANE_W+1]}}, lane_sum};

endmodule

/* hw/rtl/imru_requant.sv */
// Two-stage requantizer: registered Q31 product, then rounding, offset and clamp.
module imru_requant
(
    input  logic               clk,
    input  logic               start,
    input  logic [31:0]        acc,
    input  logic [31:0]        bias,
    input  logic [31:0]        multiplier,
    input  logic signed [5:0]  shift,
    input  logic signed [15:0] out_offset,
    input  logic signed [15:0] act_min,
    input  logic signed [15:0] act_max,
    output logic [31:0]        result
);

    logic [31:0]        sum;
    logic [4:0]         left;
    logic [31:0]        shifted;
    logic signed [63:0] prod;
    logic signed [63:0] prod_reg;
    logic               sat_reg;
    logic signed [63:0] nudged;
    logic signed [63:0] quot;
    logic [31:0]        scaled;
    logic [5:0]         neg_shift;
    logic [4:0]         right;
    logic [31:0]        mask;
    logic [31:0]        rem;
    logic [31:0]        thr;
    logic signed [31:0] rounded;
    logic signed [31:0] res;

    assign sum     = acc + bias;
    assign left    = (shift > 6'sd0) ? shift[4:0] : 5'd0;
    assign shifted = sum << left;
    assign prod    = $signed(shifted) * $signed(multiplier);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod;
            sat_reg  <= (shifted == 32'h8000_0000) && (multiplier == 32'h8000_0000);
        end
    end

    // Doubling high multiply: nudge, then divide by 2^31 truncating toward zero.
    always_comb
    begin
        nudged = prod_reg + ((prod_reg >= 64'sd0) ? 64'sh4000_0000 : -64'sh3FFF_FFFF);
        quot   = nudged >>> 31;
        if (nudged < 64'sd0 && nudged[30:0] != '0)
        begin
            quot = quot + 64'sd1;
        end
        scaled = sat_reg ? 32'h7FFF_FFFF : quot[31:0];
    end

    // Rounding right shift, capped at 31 places, then output offset and clamp.
    always_comb
    begin
        neg_shift = 6'd0 - shift;
        if (shift > 6'sd0)
        begin
            right = 5'd0;
        end
        else if (neg_shift > 6'd31)
        begin
            right = 5'd31;
        end
        else
        begin
            right = neg_shift[4:0];
        end
        mask    = (32'd1 << right) - 32'd1;
        rem     = scaled & mask;
        thr     = (mask >> 1) + {31'd0, scaled[31]};
        rounded = ($signed(scaled) >>> right) + ((rem > thr) ? 32'sd1 : 32'sd0);
        res     = rounded + {{16{out_offset[15]}}, out_offset};
        if (res < $signed({{16{act_min[15]}}, act_min}))
        begin
            res = {{16{act_min[15]}}, act_min};
        end
        if (res > $signed({{16{act_max[15]}}, act_max}))
        begin
            res = {{16{act_max[15]}}, act_max};
        end
        result = res;
    end

endmodule

/* hw/rtl/imru_store.sv */
// Circular word store with read and write pointers and a fill count.
`include "int8_mac_requant_unit_top_assert.svh"

module imru_store
#(
    parameter int  STORE_DEPTH = 256,
    localparam int PTR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
    localparam int CNT_W = $clog2(STORE_DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  imru_pkg::store_cmd_t cmd,
    output logic [31:0]          rdata,
    output logic [CNT_W-1:0]     count
);

    logic [31:0]      mem [STORE_DEPTH];
    logic [31:0]      rdata_reg;
    logic [PTR_W-1:0] rp_reg;
    logic [PTR_W-1:0] rp_next;
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr_en;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        if (cmd.clear)
        begin
            rp_next    = '0;
            wp_next    = '0;
            count_next = '0;
        end
        else if (cmd.push)
        begin
            if (count_reg < CNT_W'(STORE_DEPTH))
            begin
                wr_en      = 1'b1;
                wp_next    = ptr_inc(wp_reg);
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (cmd.take)
        begin
            wr_en   = 1'b1;
            wp_next = ptr_inc(wp_reg);
            rp_next = ptr_inc(rp_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg    <= '0;
            wp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            count_reg <= count_next;
        end
    end

    // The word at the next read pointer is always read ahead.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= cmd.wdata;
        end
        rdata_reg <= mem[rp_next];
    end

    assign rdata = rdata_reg;
    assign count = count_reg;

    `IMRU_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(STORE_DEPTH))
    `IMRU_ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.clear, count_reg == '0 && rp_reg == '0)
    `IMRU_ASSERT_NEXT(a_take_keeps_count, clk, rst_n, cmd.take && !cmd.clear && !cmd.push, $stable(count_reg))

endmodule

/* hw/rtl/int8_mac_requant_unit_top.sv */
// Top level of the int8 MAC and requantization unit.
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ----------------------------------
//  request   in_valid / in_ready    req_type, word_a, word_b
//  result    out_valid / out_ready  result_word
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// MAC, ADD, SUB, MUL, clear-accumulator and clear-store requests end in their
// first phase; PUSH and REQUANT need a second: the store has one write port and
// the Q31 product is registered before rounding. A store MAC needs a second and
// a third (neither if the store is empty), set by the registered store read and
// its single write port. Reset clears the accumulator, the store pointers and the
// configuration registers. A result waits in the output register while the next
// request is taken in; new requests are held off while a request has phases to
// run, and when a finished result would have nowhere to go.
`include "int8_mac_requant_unit_top_assert.svh"

module int8_mac_requant_unit_top
#(
    parameter int STORE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  req_type,
    input  logic [31:0] word_a,
    input  logic [31:0] word_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_THIRD} phase_t;

    // Configuration registers.
    logic signed [8:0]  in_off_reg;
    logic [31:0]        bias_reg;
    logic [31:0]        mult_reg;
    logic signed [5:0]  shift_reg;
    logic signed [15:0] out_off_reg;
    logic signed [15:0] act_min_reg;
    logic signed [15:0] act_max_reg;

    // Execution stage.
    logic        exec_valid_reg;
    logic [3:0]  op_reg;
    phase_t      phase_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] hold_reg;
    logic [31:0] acc_reg;
    logic        out_valid_reg;
    logic [31:0] result_word_reg;

    logic                  last;
    logic                  out_load;
    logic                  advance;
    logic                  accept;
    logic                  acc_upd;
    logic [31:0]           x_word;
    logic [31:0]           y_word;
    logic [31:0]           dot_sum;
    logic [31:0]           requant_res;
    logic [31:0]           result_next;
    logic [31:0]           store_rdata;
    logic [CNT_W-1:0]      store_count;
    logic                  cnt_zero;
    logic                  cnt_one;
    imru_pkg::store_cmd_t  store_cmd;
    imru_pkg::lane_prod_t  products [imru_pkg::NUM_LANES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_off_reg  <= '0;
            bias_reg    <= '0;
            mult_reg    <= '0;
            shift_reg   <= '0;
            out_off_reg <= '0;
            act_min_reg <= '0;
            act_max_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                imru_pkg::CFG_INPUT_OFFSET:  in_off_reg  <= cfg_data[8:0];
                imru_pkg::CFG_BIAS:          bias_reg    <= cfg_data;
                imru_pkg::CFG_MULTIPLIER:    mult_reg    <= cfg_data;
                imru_pkg::CFG_SHIFT:         shift_reg   <= cfg_data[5:0];
                imru_pkg::CFG_OUTPUT_OFFSET: out_off_reg <= cfg_data[15:0];
                imru_pkg::CFG_ACT_MIN:       act_min_reg <= cfg_data[15:0];
                imru_pkg::CFG_ACT_MAX:       act_max_reg <= cfg_data[15:0];
                default:                     ;
            endcase
        end
    end

    assign cnt_zero = (store_count == '0);
    assign cnt_one  = (store_count == CNT_W'(1));

    // Which phase finishes the request held in the execution stage.
    always_comb
    begin
        case (op_reg) inside
            imru_pkg::OP_PUSH,
            imru_pkg::OP_REQUANT: last = (phase_reg == PH_SECOND);
            imru_pkg::OP_BUFMAC:  last = cnt_zero || (phase_reg == PH_THIRD);
            default:              last = 1'b1;
        endcase
    end

    assign out_load = exec_valid_reg && last && (!out_valid_reg || out_ready);
    assign advance  = exec_valid_reg && (!last || out_load);
    assign in_ready = !exec_valid_reg || out_load;
    assign accept   = in_valid && in_ready;

    // Operand selection for the shared lanes. With one stored word, the second
    // filter word meets the same stored word again.
    assign x_word = (phase_reg == PH_THIRD) ? b_reg : a_reg;
    always_comb
    begin
        if (op_reg == imru_pkg::OP_MAC)
        begin
            y_word = b_reg;
        end
        else if (phase_reg == PH_THIRD && cnt_one)
        begin
            y_word = hold_reg;
        end
        else
        begin
            y_word = store_rdata;
        end
    end

    for (genvar i = 0; i < imru_pkg::NUM_LANES; i++)
    begin : g_lane
        imru_lane u_lane
        (
            .a_byte  (x_word[8*i +: 8]),
            .b_byte  (y_word[8*i +: 8]),
            .offset  (in_off_reg),
            .product (products[i])
        );
    end

    imru_merge u_merge
    (
        .acc      (acc_reg),
        .products (products),
        .sum      (dot_sum)
    );

    imru_requant u_requant
    (
        .clk        (clk),
        .start      (advance && op_reg == imru_pkg::OP_REQUANT && phase_reg == PH_FIRST),
        .acc        (acc_reg),
        .bias       (bias_reg),
        .multiplier (mult_reg),
        .shift      (shift_reg),
        .out_offset (out_off_reg),
        .act_min    (act_min_reg),
        .act_max    (act_max_reg),
        .result     (requant_res)
    );

    // Store commands: pushes write one word a cycle unless a full output register
    // stalls the second; a store MAC rotates each word it uses back to the tail.
    always_comb
    begin
        store_cmd = '0;
        case (op_reg)
            imru_pkg::OP_PUSH:
            begin
                store_cmd.push  = (phase_reg == PH_FIRST) ? advance : out_load;
                store_cmd.wdata = (phase_reg == PH_FIRST) ? a_reg : b_reg;
            end
            imru_pkg::OP_BUFMAC:
            begin
                store_cmd.take  = (phase_reg == PH_SECOND && advance) ||
                                  (phase_reg == PH_THIRD && out_load);
                store_cmd.wdata = y_word;
            end
            imru_pkg::OP_CLRBUF:
            begin
                store_cmd.clear = out_load;
            end
            default:
            begin
                store_cmd.push = 1'b0;
            end
        endcase
    end

    imru_store #(.STORE_DEPTH(STORE_DEPTH)) u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (store_cmd),
        .rdata (store_rdata),
        .count (store_count)
    );

    assign acc_upd = (op_reg == imru_pkg::OP_MAC && out_load) ||
                     (op_reg == imru_pkg::OP_BUFMAC &&
                      ((phase_reg == PH_SECOND && advance) ||
                       (phase_reg == PH_THIRD && out_load)));

    always_comb
    begin
        case (op_reg)
            imru_pkg::OP_MAC:     result_next = dot_sum;
            imru_pkg::OP_BUFMAC:  result_next = cnt_zero ? acc_reg : dot_sum;
            imru_pkg::OP_REQUANT: result_next = requant_res;
            imru_pkg::OP_ADD:     result_next = a_reg + b_reg;
            imru_pkg::OP_SUB:     result_next = a_reg - b_reg;
            imru_pkg::OP_MUL:     result_next = a_reg * b_reg;
            default:              result_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg  <= 1'b0;
            op_reg          <= imru_pkg::OP_MAC;
            phase_reg       <= PH_FIRST;
            acc_reg         <= '0;
            out_valid_reg   <= 1'b0;
            result_word_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                exec_valid_reg <= 1'b1;
                op_reg         <= req_type;
                phase_reg      <= PH_FIRST;
            end
            else if (advance)
            begin
                if (last)
                begin
                    exec_valid_reg <= 1'b0;
                    phase_reg      <= PH_FIRST;
                end
                else
                begin
                    phase_reg <= (phase_reg == PH_FIRST) ? PH_SECOND : PH_THIRD;
                end
            end
            if (acc_upd)
            begin
                acc_reg <= dot_sum;
            end
            else if (op_reg == imru_pkg::OP_CLRACC && out_load)
            begin
                acc_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg   <= 1'b1;
                result_word_reg <= result_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= word_a;
            b_reg <= word_b;
        end
        if (op_reg == imru_pkg::OP_BUFMAC && phase_reg == PH_SECOND)
        begin
            hold_reg <= store_rdata;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_word = result_word_reg;

    `IMRU_ASSERT_NEXT(a_accept_fills_exec, clk, rst_n, in_valid && in_ready, exec_valid_reg)
    `IMRU_ASSERT_NEXT(a_finish_fills_out, clk, rst_n, out_load, out_valid_reg)
    `IMRU_ASSERT_IMPL(a_bufmac_needs_words, clk, rst_n, exec_valid_reg && op_reg == imru_pkg::OP_BUFMAC && phase_reg != PH_FIRST, store_count != '0)
    `IMRU_ASSERT_NEXT(a_clracc_zero, clk, rst_n, out_load && op_reg == imru_pkg::OP_CLRACC, acc_reg == '0)

endmodule
